[src/wspm_pkg.sv]
// Shared types, field widths, register codes and control structs for the working-set page monitor.
package wspm_pkg;

  localparam int PSIZE_W    = 16;
  localparam int ILEN_W     = 16;
  localparam int NPAGES_W   = 13;
  localparam int POS_W      = 32;
  localparam int REFS_W     = 16;
  localparam int DIST_W     = 13;
  localparam int ILL_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef logic [PSIZE_W-1:0]    psize_t;
  typedef logic [ILEN_W-1:0]     ilen_t;
  typedef logic [NPAGES_W-1:0]   npages_t;
  typedef logic [POS_W-1:0]      pos_t;
  typedef logic [REFS_W-1:0]     refs_t;
  typedef logic [DIST_W-1:0]     dist_t;
  typedef logic [ILL_W-1:0]      ill_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // register indexes
  localparam cfg_idx_t CFG_PAGE_SIZE    = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_INTERVAL_LEN = cfg_idx_t'(1);
  localparam cfg_idx_t CFG_NUM_PAGES    = cfg_idx_t'(2);

  // register reset values
  localparam psize_t  PSIZE_RST  = psize_t'(16);
  localparam ilen_t   ILEN_RST   = ilen_t'(2000);
  localparam npages_t NPAGES_RST = npages_t'(63);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_UPD,
    ST_REPORT,
    ST_CLR_RD,
    ST_CLR_WR
  } state_t;

  typedef struct packed {
    logic load;       // latch accepted item, arm divider
    logic div_step;   // one quotient bit
    logic bump_ill;   // count an illegal reference
    logic rd_bit;     // read bitmap at the page
    logic upd;        // apply the reference to bitmap and counters
    logic emit_roll;  // load the report and roll or clear the counters
    logic clr_rd;     // read the next touched page from the list
    logic clr_wr;     // clear that page in the bitmap
    logic clr_done;   // list walked, drop the distinct count
    logic init_wr;    // post-reset sweep write
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic illegal;
    logic due;
    logic out_free;
    logic pages_zero;
    logic clr_last;
    logic init_last;
  } stat_t;

endpackage

[src/wspm_ifs.sv]
// Valid/ready channel interfaces: reference items, reports and register writes.
interface wspm_in_if #(parameter int ELEM_W = 24) ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [ELEM_W-1:0] element_index;

  modport source(output valid, output req_type, output element_index, input ready);
  modport sink(input valid, input req_type, input element_index, output ready);
endinterface

interface wspm_out_if ();
  logic                  valid;
  logic                  ready;
  wspm_pkg::pos_t        position;
  wspm_pkg::refs_t       interval_refs;
  wspm_pkg::dist_t       distinct_pages;
  wspm_pkg::ill_t        illegal_count;
  logic                  is_final;

  modport source(output valid, output position, output interval_refs,
                 output distinct_pages, output illegal_count, output is_final,
                 input ready);
  modport sink(input valid, input position, input interval_refs,
               input distinct_pages, input illegal_count, input is_final,
               output ready);
endinterface

interface wspm_cfg_if ();
  logic                valid;
  logic                ready;
  wspm_pkg::cfg_idx_t  index;
  wspm_pkg::cfg_data_t data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

[src/wspm_ctrl.sv]
// Controller state machine: sequences the post-reset sweep, divide, bitmap update, report and bitmap clearing.
module wspm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_flush,
  output logic             in_ready,
  output wspm_pkg::cmd_t   cmd,
  input  wspm_pkg::stat_t  stat
);

  wspm_pkg::state_t state_r;
  wspm_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wspm_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wspm_pkg::ST_INIT: begin
        if (stat.init_last) state_nxt = wspm_pkg::ST_IDLE;
      end
      wspm_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = in_flush ? wspm_pkg::ST_REPORT : wspm_pkg::ST_DIV;
      end
      wspm_pkg::ST_DIV: begin
        if (stat.div_last) state_nxt = wspm_pkg::ST_CHECK;
      end
      wspm_pkg::ST_CHECK: begin
        state_nxt = stat.illegal ? wspm_pkg::ST_IDLE : wspm_pkg::ST_UPD;
      end
      wspm_pkg::ST_UPD: begin
        state_nxt = stat.due ? wspm_pkg::ST_REPORT : wspm_pkg::ST_IDLE;
      end
      wspm_pkg::ST_REPORT: begin
        if (stat.out_free) begin
          state_nxt = stat.pages_zero ? wspm_pkg::ST_IDLE : wspm_pkg::ST_CLR_RD;
        end
      end
      wspm_pkg::ST_CLR_RD: begin
        state_nxt = wspm_pkg::ST_CLR_WR;
      end
      wspm_pkg::ST_CLR_WR: begin
        state_nxt = stat.clr_last ? wspm_pkg::ST_IDLE : wspm_pkg::ST_CLR_RD;
      end
      default: begin
        state_nxt = wspm_pkg::ST_INIT;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      wspm_pkg::ST_INIT: begin
        cmd.init_wr = 1'b1;
      end
      wspm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      wspm_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      wspm_pkg::ST_CHECK: begin
        cmd.bump_ill = stat.illegal;
        cmd.rd_bit   = !stat.illegal;
      end
      wspm_pkg::ST_UPD: begin
        cmd.upd = 1'b1;
      end
      wspm_pkg::ST_REPORT: begin
        cmd.emit_roll = stat.out_free;
      end
      wspm_pkg::ST_CLR_RD: begin
        cmd.clr_rd = 1'b1;
      end
      wspm_pkg::ST_CLR_WR: begin
        cmd.clr_wr   = 1'b1;
        cmd.clr_done = stat.clr_last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == wspm_pkg::ST_DIV || state_r == wspm_pkg::ST_REPORT)
    else $error("accepted item did not start divide or report");

  a_upd_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == wspm_pkg::ST_UPD |-> $past(state_r) == wspm_pkg::ST_CHECK)
    else $error("bitmap update without a preceding read");

endmodule

[src/wspm_dp.sv]
// Datapath: config registers, restoring divider, page bitmap, touched-page list and report register.
module wspm_dp #(
  parameter int MAX_PAGES    = 4096,
  parameter int ELEMENT_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  wspm_pkg::cmd_t           cmd,
  output wspm_pkg::stat_t          stat,
  input  logic                     in_req_type,
  input  logic [ELEMENT_BITS-1:0]  in_element,
  wspm_cfg_if.sink                 cfg_ch,
  wspm_out_if.source               out_ch
);

  localparam int PW  = $clog2(MAX_PAGES);
  localparam int CW  = $clog2(MAX_PAGES + 1);
  localparam int DCW = $clog2(ELEMENT_BITS);

  // config
  wspm_pkg::psize_t  page_size_r;
  wspm_pkg::ilen_t   ilen_r;
  wspm_pkg::npages_t npages_r;

  // item / divider
  logic                      flush_r;
  logic [ELEMENT_BITS-1:0]   dvd_r;
  wspm_pkg::psize_t          rem_r;
  logic [DCW-1:0]            div_cnt_r;

  // interval state
  wspm_pkg::refs_t           refs_r;
  logic [CW-1:0]             pages_r;
  wspm_pkg::pos_t            total_r;
  wspm_pkg::ill_t            illegal_r;
  logic [PW-1:0]             init_idx_r;
  logic [PW-1:0]             clr_idx_r;
  logic                      bit_q_r;
  logic [PW-1:0]             list_q_r;

  // report register
  logic                      out_valid_r;
  wspm_pkg::pos_t            out_pos_r;
  wspm_pkg::refs_t           out_refs_r;
  wspm_pkg::dist_t           out_dist_r;
  wspm_pkg::ill_t            out_ill_r;
  logic                      out_final_r;

  logic                      bits_mem [MAX_PAGES];
  logic [PW-1:0]             list_mem [MAX_PAGES];

  logic [wspm_pkg::PSIZE_W:0] trial_w;
  logic [wspm_pkg::PSIZE_W:0] diff_w;
  logic                       ge_w;
  logic [32:0]                quot_w;
  logic [32:0]                limit_w;
  logic [PW-1:0]              page_w;
  logic [wspm_pkg::REFS_W:0]  refs_inc_w;
  logic [31:0]                dist_w;
  logic                       new_page_w;
  logic                       mem_we;
  logic [PW-1:0]              mem_wa;
  logic                       mem_wd;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_size_r <= wspm_pkg::PSIZE_RST;
      ilen_r      <= wspm_pkg::ILEN_RST;
      npages_r    <= wspm_pkg::NPAGES_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        wspm_pkg::CFG_PAGE_SIZE:    page_size_r <= cfg_ch.data;
        wspm_pkg::CFG_INTERVAL_LEN: ilen_r      <= cfg_ch.data;
        wspm_pkg::CFG_NUM_PAGES:    npages_r    <= cfg_ch.data[wspm_pkg::NPAGES_W-1:0];
        default: ;
      endcase
    end
  end

  // restoring divide, one quotient bit per step; dvd_r ends up holding the quotient
  assign trial_w = {rem_r, dvd_r[ELEMENT_BITS-1]};
  assign diff_w  = trial_w - {1'b0, page_size_r};
  assign ge_w    = trial_w >= {1'b0, page_size_r};

  assign quot_w  = 33'(dvd_r);
  assign limit_w = (33'(npages_r) > 33'(MAX_PAGES)) ? 33'(MAX_PAGES) : 33'(npages_r);
  assign page_w  = quot_w[PW-1:0];

  assign refs_inc_w = {1'b0, refs_r} + 1'b1;
  assign dist_w     = 32'(pages_r);
  assign new_page_w = cmd.upd && !bit_q_r;

  always_comb begin
    stat.div_last   = div_cnt_r == DCW'(ELEMENT_BITS - 1);
    stat.illegal    = (page_size_r == '0) || (quot_w >= limit_w);
    stat.due        = refs_inc_w >= {1'b0, ilen_r};
    stat.out_free   = !out_valid_r || out_ch.ready;
    stat.pages_zero = pages_r == '0;
    stat.clr_last   = (CW'(clr_idx_r) + CW'(1)) == pages_r;
    stat.init_last  = init_idx_r == PW'(MAX_PAGES - 1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      flush_r <= in_req_type;
      dvd_r   <= in_element;
      rem_r   <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge_w ? diff_w[wspm_pkg::PSIZE_W-1:0] : trial_w[wspm_pkg::PSIZE_W-1:0];
      dvd_r <= {dvd_r[ELEMENT_BITS-2:0], ge_w};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.load) begin
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  // single write port on the bitmap: sweep, set, or clear a listed page
  always_comb begin
    mem_we = 1'b0;
    mem_wa = init_idx_r;
    mem_wd = 1'b0;
    if (cmd.init_wr) begin
      mem_we = 1'b1;
    end else if (new_page_w) begin
      mem_we = 1'b1;
      mem_wa = page_w;
      mem_wd = 1'b1;
    end else if (cmd.clr_wr) begin
      mem_we = 1'b1;
      mem_wa = list_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) bits_mem[mem_wa] <= mem_wd;
    if (cmd.rd_bit) bit_q_r <= bits_mem[page_w];
  end

  always_ff @(posedge clk) begin
    if (new_page_w) list_mem[pages_r[PW-1:0]] <= page_w;
    if (cmd.clr_rd) list_q_r <= list_mem[clr_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refs_r     <= '0;
      pages_r    <= '0;
      total_r    <= '0;
      illegal_r  <= '0;
      init_idx_r <= '0;
      clr_idx_r  <= '0;
    end else begin
      if (cmd.init_wr) init_idx_r <= init_idx_r + 1'b1;
      if (cmd.bump_ill && (illegal_r != '1)) illegal_r <= illegal_r + 1'b1;
      if (cmd.upd) begin
        refs_r <= refs_inc_w[wspm_pkg::REFS_W-1:0];
        if (!bit_q_r) pages_r <= pages_r + 1'b1;
      end
      if (cmd.emit_roll) begin
        refs_r <= '0;
        if (flush_r) begin
          total_r   <= '0;
          illegal_r <= '0;
        end else begin
          total_r <= total_r + wspm_pkg::pos_t'(refs_r);
        end
      end
      if (cmd.clr_wr) clr_idx_r <= clr_idx_r + 1'b1;
      if (cmd.clr_done) begin
        pages_r   <= '0;
        clr_idx_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_roll) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_roll) begin
      out_pos_r   <= total_r;
      out_refs_r  <= refs_r;
      out_dist_r  <= dist_w[wspm_pkg::DIST_W-1:0];
      out_ill_r   <= flush_r ? illegal_r : '0;
      out_final_r <= flush_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.position       = out_pos_r;
  assign out_ch.interval_refs  = out_refs_r;
  assign out_ch.distinct_pages = out_dist_r;
  assign out_ch.illegal_count  = out_ill_r;
  assign out_ch.is_final       = out_final_r;

  a_interval_report_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_final_r |->
      out_refs_r != '0 && out_dist_r != '0 &&
      wspm_pkg::refs_t'(out_dist_r) <= out_refs_r)
    else $error("interval report with inconsistent counts");

  a_illegal_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(cmd.emit_roll && flush_r) |-> illegal_r >= $past(illegal_r))
    else $error("illegal count dropped outside a flush");

endmodule

[src/working_set_page_monitor.sv]
// Top level of the working-set page monitor: controller plus datapath.
// Reference item: accepted in idle, divided by the one-bit-per-cycle divider, checked for a
// legal page, then applied to the bitmap; an illegal page skips the update. No new item is
// taken until the last is through. A report waits for a free output register, then walks the
// touched-page list, reading and clearing each page; a flush goes straight to report and walk.
// Results sit in an output register, so the next item is taken while a report waits.
// After rst_n the whole bitmap is swept with input ready low; config is always taken.
module working_set_page_monitor #(
  parameter int MAX_PAGES    = 4096,
  parameter int ELEMENT_BITS = 24
) (
  input logic         clk,
  input logic         rst_n,
  wspm_in_if.sink     in_ch,
  wspm_out_if.source  out_ch,
  wspm_cfg_if.sink    cfg_ch
);

  wspm_pkg::cmd_t  cmd;
  wspm_pkg::stat_t stat;
  logic            in_ready;

  assign in_ch.ready = in_ready;

  wspm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_flush (in_ch.req_type),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  wspm_dp #(
    .MAX_PAGES    (MAX_PAGES),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_req_type (in_ch.req_type),
    .in_element  (in_ch.element_index),
    .cfg_ch      (cfg_ch),
    .out_ch      (out_ch)
  );

endmodule
